// File: rtl/pq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pq_pkg
// Shared types, widths and codes of the priority event queue.
// ----------------------------------------------------------------------------
package pq_pkg;

  localparam int PQ_DEPTH_DEF = 16;
  localparam int PQ_MAX_RX    = 32;

  localparam int PQ_ID_W   = 5;
  localparam int PQ_BYTE_W = 8;
  localparam int PQ_WORD_W = 32;
  localparam int PQ_MASK_W = 32;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NO_RX = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // header entry, 34 bits
  typedef struct packed {
    logic [PQ_BYTE_W-1:0] urgency;
    logic [PQ_BYTE_W-1:0] tag;
    logic [PQ_BYTE_W-1:0] kind;
    logic [PQ_ID_W-1:0]   sender;
    logic [PQ_ID_W-1:0]   receiver;
  } hdr_t;

  // body entry, 64 bits
  typedef struct packed {
    logic [PQ_WORD_W-1:0] handle;
    logic [PQ_WORD_W-1:0] payload;
  } body_t;

  function automatic logic rx_enabled(logic [PQ_MASK_W-1:0] mask, logic [PQ_ID_W-1:0] rx);
    return (int'(rx) < PQ_MAX_RX) && mask[rx];
  endfunction

endpackage
`default_nettype wire

// File: rtl/priority_event_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Priority event queue of QUEUE_DEPTH slots. Events are kept in a linked list
// ordered by urgency (smaller first, equal urgency in arrival order) inside
// synchronous header, body and link memories; free slots form a second list.
// One request is handled at a time and gives one result. A push walks the
// list from the head, comparing queued events in order, at most as many as
// the queue holds; the walk reads one link-memory entry per cycle. A finished
// result waits in the output register, and the next request is taken while
// it waits; that request then holds in its last state until the output
// register is free.
// ----------------------------------------------------------------------------
// priority_event_queue_top
// Top level: request sequencer with event and link stores.
// ----------------------------------------------------------------------------
module priority_event_queue_top
  import pq_pkg::*;
#(
  parameter int QUEUE_DEPTH = PQ_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [PQ_MASK_W-1:0] cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_req_type,
  input  wire logic [PQ_ID_W-1:0]   in_receiver_id,
  input  wire logic [PQ_ID_W-1:0]   in_sender_id,
  input  wire logic [PQ_BYTE_W-1:0] in_kind,
  input  wire logic [PQ_BYTE_W-1:0] in_tag,
  input  wire logic [PQ_WORD_W-1:0] in_payload_word,
  input  wire logic [PQ_WORD_W-1:0] in_data_handle,
  input  wire logic [PQ_BYTE_W-1:0] in_urgency,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_status,
  output logic                      out_deliver,
  output logic [PQ_ID_W-1:0]        out_receiver,
  output logic [PQ_ID_W-1:0]        out_sender,
  output logic [PQ_BYTE_W-1:0]      out_kind,
  output logic [PQ_BYTE_W-1:0]      out_tag,
  output logic [PQ_WORD_W-1:0]      out_payload,
  output logic [PQ_WORD_W-1:0]      out_handle
);

  localparam int IW = $clog2(QUEUE_DEPTH);

  hdr_t          in_hdr, out_hdr, st_rd_hdr;
  body_t         in_body, out_body, st_rd_body;
  logic          st_wr_en, lk_wr_en;
  logic [IW-1:0] st_wr_addr, rd_addr, lk_wr_addr, lk_wr_data, lk_rd_data;

  assign in_hdr.receiver = in_receiver_id;
  assign in_hdr.sender   = in_sender_id;
  assign in_hdr.kind     = in_kind;
  assign in_hdr.tag      = in_tag;
  assign in_hdr.urgency  = in_urgency;
  assign in_body.payload = in_payload_word;
  assign in_body.handle  = in_data_handle;

  pq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_hdr      (in_hdr),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_deliver (out_deliver),
    .out_hdr     (out_hdr),
    .out_body    (out_body),
    .st_wr_en    (st_wr_en),
    .st_wr_addr  (st_wr_addr),
    .rd_addr     (rd_addr),
    .st_rd_hdr   (st_rd_hdr),
    .st_rd_body  (st_rd_body),
    .lk_wr_en    (lk_wr_en),
    .lk_wr_addr  (lk_wr_addr),
    .lk_wr_data  (lk_wr_data),
    .lk_rd_data  (lk_rd_data)
  );

  pq_evt_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_evt_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_hdr  (in_hdr),
    .wr_body (in_body),
    .rd_addr (rd_addr),
    .rd_hdr  (st_rd_hdr),
    .rd_body (st_rd_body)
  );

  pq_link_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_link_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (lk_wr_en),
    .wr_addr (lk_wr_addr),
    .wr_data (lk_wr_data),
    .rd_addr (rd_addr),
    .rd_data (lk_rd_data)
  );

  assign out_receiver = out_hdr.receiver;
  assign out_sender   = out_hdr.sender;
  assign out_kind     = out_hdr.kind;
  assign out_tag      = out_hdr.tag;
  assign out_payload  = out_body.payload;
  assign out_handle   = out_body.handle;

endmodule
`default_nettype wire

// File: rtl/pq_evt_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pq_evt_store
// Header and body memories of the event slots, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
module pq_evt_store
  import pq_pkg::*;
#(
  parameter int QUEUE_DEPTH = PQ_DEPTH_DEF,
  localparam int IW = $clog2(QUEUE_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [IW-1:0] wr_addr,
  input  wire hdr_t          wr_hdr,
  input  wire body_t         wr_body,
  input  wire logic [IW-1:0] rd_addr,
  output hdr_t               rd_hdr,
  output body_t              rd_body
);

  hdr_t  hdr_mem  [QUEUE_DEPTH];
  body_t body_mem [QUEUE_DEPTH];
  hdr_t  rd_hdr_r;
  body_t rd_body_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hdr_mem[wr_addr]  <= wr_hdr;
      body_mem[wr_addr] <= wr_body;
    end
    rd_hdr_r  <= hdr_mem[rd_addr];
    rd_body_r <= body_mem[rd_addr];
  end

  assign rd_hdr  = rd_hdr_r;
  assign rd_body = rd_body_r;

endmodule
`default_nettype wire

// File: rtl/pq_link_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pq_link_store
// Next-slot link memory. An entry never written reads as the following
// slot, so after reset all slots form the free list.
// ----------------------------------------------------------------------------
module pq_link_store
  import pq_pkg::*;
#(
  parameter int QUEUE_DEPTH = PQ_DEPTH_DEF,
  localparam int IW = $clog2(QUEUE_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [IW-1:0] wr_addr,
  input  wire logic [IW-1:0] wr_data,
  input  wire logic [IW-1:0] rd_addr,
  output logic      [IW-1:0] rd_data
);

  logic [IW-1:0]          link_mem [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] vld_r;
  logic [IW-1:0]          mem_q_r;
  logic [IW-1:0]          addr_q_r;
  logic                   vld_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    mem_q_r  <= link_mem[rd_addr];
    vld_q_r  <= vld_r[rd_addr];
    addr_q_r <= rd_addr;
  end

  // reset chain: slot i links to i+1, wrapping at the last slot
  always_comb begin
    if (vld_q_r) begin
      rd_data = mem_q_r;
    end else if (addr_q_r == IW'(QUEUE_DEPTH - 1)) begin
      rd_data = '0;
    end else begin
      rd_data = addr_q_r + IW'(1);
    end
  end

endmodule
`default_nettype wire

// File: rtl/pq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pq_ctrl
// Request sequencer: slot allocation, ordered list walk, link updates,
// receiver mask and result register.
// ----------------------------------------------------------------------------
module pq_ctrl
  import pq_pkg::*;
#(
  parameter int QUEUE_DEPTH = PQ_DEPTH_DEF,
  localparam int IW = $clog2(QUEUE_DEPTH),
  localparam int OW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [PQ_MASK_W-1:0] cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_req_type,
  input  wire hdr_t                 in_hdr,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_status,
  output logic                      out_deliver,
  output hdr_t                      out_hdr,
  output body_t                     out_body,
  // event store
  output logic                      st_wr_en,
  output logic [IW-1:0]             st_wr_addr,
  output logic [IW-1:0]             rd_addr,
  input  wire hdr_t                 st_rd_hdr,
  input  wire body_t                st_rd_body,
  // link store
  output logic                      lk_wr_en,
  output logic [IW-1:0]             lk_wr_addr,
  output logic [IW-1:0]             lk_wr_data,
  input  wire logic [IW-1:0]        lk_rd_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ALLOC = 6'b000010,
    S_WALK  = 6'b000100,
    S_FIX   = 6'b001000,
    S_POP   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [IW-1:0]        head_r, free_head_r;
  logic [OW-1:0]        occ_r;
  logic [PQ_MASK_W-1:0] mask_r;
  logic [IW-1:0]        slot_r, cur_r, prev_r;
  logic                 have_prev_r;
  logic [OW-1:0]        cnt_r;
  logic [PQ_BYTE_W-1:0] urg_r;
  status_t              res_status_r;
  logic                 res_deliver_r;
  hdr_t                 res_hdr_r;
  body_t                res_body_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic                 out_deliver_r;
  hdr_t                 out_hdr_r;
  body_t                out_body_r;

  logic accept, out_load, push_en, is_full, is_empty, urg_gt, at_tail;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign push_en  = rx_enabled(mask_r, in_hdr.receiver);
  assign is_full  = (occ_r == OW'(QUEUE_DEPTH));
  assign is_empty = (occ_r == '0);
  // new event goes before the first queued event of strictly greater urgency
  assign urg_gt   = st_rd_hdr.urgency > urg_r;
  assign at_tail  = (cnt_r + OW'(1)) == occ_r;

  assign st_wr_en   = accept && (in_req_type == REQ_PUSH) && push_en && !is_full;
  assign st_wr_addr = free_head_r;

  always_comb begin
    state_nxt  = state_r;
    lk_wr_en   = 1'b0;
    lk_wr_addr = slot_r;
    lk_wr_data = cur_r;
    rd_addr    = head_r;
    case (state_r)
      S_IDLE: begin
        rd_addr = (in_req_type == REQ_POP) ? head_r : free_head_r;
        if (accept) begin
          if (in_req_type == REQ_POP) begin
            state_nxt = is_empty ? S_DONE : S_POP;
          end else begin
            state_nxt = st_wr_en ? S_ALLOC : S_DONE;
          end
        end
      end
      S_ALLOC: begin
        rd_addr   = head_r;
        state_nxt = is_empty ? S_DONE : S_WALK;
      end
      S_WALK: begin
        if (urg_gt) begin
          lk_wr_en   = 1'b1;
          lk_wr_addr = slot_r;
          lk_wr_data = cur_r;
          state_nxt  = have_prev_r ? S_FIX : S_DONE;
        end else if (at_tail) begin
          lk_wr_en   = 1'b1;
          lk_wr_addr = cur_r;
          lk_wr_data = slot_r;
          state_nxt  = S_DONE;
        end else begin
          rd_addr = lk_rd_data;
        end
      end
      S_FIX: begin
        lk_wr_en   = 1'b1;
        lk_wr_addr = prev_r;
        lk_wr_data = slot_r;
        state_nxt  = S_DONE;
      end
      S_POP: begin
        lk_wr_en   = 1'b1;
        lk_wr_addr = head_r;
        lk_wr_data = free_head_r;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      free_head_r <= '0;
      occ_r       <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        mask_r <= cfg_wr_data;
      end
      case (state_r)
        S_ALLOC: begin
          free_head_r <= lk_rd_data;
          if (is_empty) begin
            head_r <= slot_r;
            occ_r  <= occ_r + OW'(1);
          end
        end
        S_WALK: begin
          if (urg_gt || at_tail) begin
            occ_r <= occ_r + OW'(1);
          end
          if (urg_gt && !have_prev_r) begin
            head_r <= slot_r;
          end
        end
        S_POP: begin
          head_r      <= lk_rd_data;
          free_head_r <= head_r;
          occ_r       <= occ_r - OW'(1);
        end
        default: begin
        end
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      urg_r         <= in_hdr.urgency;
      slot_r        <= free_head_r;
      res_deliver_r <= 1'b0;
      res_hdr_r     <= '0;
      res_body_r    <= '0;
      if (in_req_type == REQ_POP) begin
        res_status_r <= is_empty ? ST_EMPTY : ST_OK;
      end else if (!push_en) begin
        res_status_r <= ST_NO_RX;
      end else if (is_full) begin
        res_status_r <= ST_FULL;
      end else begin
        res_status_r <= ST_OK;
      end
    end
    if (state_r == S_ALLOC) begin
      cur_r       <= head_r;
      cnt_r       <= '0;
      have_prev_r <= 1'b0;
    end
    if ((state_r == S_WALK) && !urg_gt && !at_tail) begin
      prev_r      <= cur_r;
      have_prev_r <= 1'b1;
      cur_r       <= lk_rd_data;
      cnt_r       <= cnt_r + OW'(1);
    end
    if (state_r == S_POP) begin
      res_hdr_r     <= st_rd_hdr;
      res_body_r    <= st_rd_body;
      res_deliver_r <= rx_enabled(mask_r, st_rd_hdr.receiver);
    end
    if (out_load) begin
      out_status_r  <= res_status_r;
      out_deliver_r <= res_deliver_r;
      out_hdr_r     <= res_hdr_r;
      out_body_r    <= res_body_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_deliver = out_deliver_r;
  assign out_hdr     = out_hdr_r;
  assign out_body    = out_body_r;

endmodule
`default_nettype wire

// File: tb/priority_event_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_event_queue_top_tb
// Sends push and pop requests under several receiver masks and checks every
// result against an urgency-sorted model queue kept by a small scoreboard.
// ----------------------------------------------------------------------------
module priority_event_queue_top_tb;
  import pq_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_PCT      = 15;

  typedef struct packed {
    logic [PQ_ID_W-1:0]   receiver;
    logic [PQ_ID_W-1:0]   sender;
    logic [PQ_BYTE_W-1:0] kind;
    logic [PQ_BYTE_W-1:0] tag;
    logic [PQ_WORD_W-1:0] payload;
    logic [PQ_WORD_W-1:0] handle;
    logic [PQ_BYTE_W-1:0] urgency;
  } event_rec_t;

  typedef struct packed {
    status_t              status;
    logic                 deliver;
    logic [PQ_ID_W-1:0]   receiver;
    logic [PQ_ID_W-1:0]   sender;
    logic [PQ_BYTE_W-1:0] kind;
    logic [PQ_BYTE_W-1:0] tag;
    logic [PQ_WORD_W-1:0] payload;
    logic [PQ_WORD_W-1:0] handle;
  } result_t;

  class event_queue_scoreboard;
    event_rec_t           queued_events[$];
    result_t              expected_results[$];
    logic [PQ_MASK_W-1:0] rx_mask;
    int                   depth;
    int                   errors;
    int                   results_seen;

    function new(int depth_i);
      depth        = depth_i;
      rx_mask      = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function bit rx_on(logic [PQ_ID_W-1:0] rx);
      return rx_mask[rx] === 1'b1;
    endfunction

    // each request gives one result, worked out when the request is taken
    function void note_request(bit is_pop, event_rec_t ev);
      result_t    r;
      event_rec_t head;
      int         pos;
      r = '0;
      if (!is_pop) begin
        if (!rx_on(ev.receiver)) begin
          r.status = ST_NO_RX;
        end else if (queued_events.size() >= depth) begin
          r.status = ST_FULL;
        end else begin
          // lands in front of the first event with strictly greater urgency
          pos = 0;
          while (pos < queued_events.size() && queued_events[pos].urgency <= ev.urgency)
            pos++;
          queued_events.insert(pos, ev);
          r.status = ST_OK;
        end
      end else if (queued_events.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        head       = queued_events.pop_front();
        r.status   = ST_OK;
        r.deliver  = rx_on(head.receiver);
        r.receiver = head.receiver;
        r.sender   = head.sender;
        r.kind     = head.kind;
        r.tag      = head.tag;
        r.payload  = head.payload;
        r.handle   = head.handle;
      end
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] result %0d: %s", $time, results_seen, msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        report($sformatf("no request waiting, status %0d", got.status));
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.deliver !== want.deliver)
          report($sformatf("deliver %0b, expected %0b", got.deliver, want.deliver));
        if (got.receiver !== want.receiver)
          report($sformatf("receiver %0d, expected %0d", got.receiver, want.receiver));
        if (got.sender !== want.sender)
          report($sformatf("sender %0d, expected %0d", got.sender, want.sender));
        if (got.kind !== want.kind)
          report($sformatf("kind %0h, expected %0h", got.kind, want.kind));
        if (got.tag !== want.tag)
          report($sformatf("tag %0h, expected %0h", got.tag, want.tag));
        if (got.payload !== want.payload)
          report($sformatf("payload %0h, expected %0h", got.payload, want.payload));
        if (got.handle !== want.handle)
          report($sformatf("handle %0h, expected %0h", got.handle, want.handle));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [PQ_MASK_W-1:0] cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_req_type = REQ_PUSH;
  logic [PQ_ID_W-1:0]   in_receiver_id = '0;
  logic [PQ_ID_W-1:0]   in_sender_id = '0;
  logic [PQ_BYTE_W-1:0] in_kind = '0;
  logic [PQ_BYTE_W-1:0] in_tag = '0;
  logic [PQ_WORD_W-1:0] in_payload_word = '0;
  logic [PQ_WORD_W-1:0] in_data_handle = '0;
  logic [PQ_BYTE_W-1:0] in_urgency = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_status;
  logic                 out_deliver;
  logic [PQ_ID_W-1:0]   out_receiver;
  logic [PQ_ID_W-1:0]   out_sender;
  logic [PQ_BYTE_W-1:0] out_kind;
  logic [PQ_BYTE_W-1:0] out_tag;
  logic [PQ_WORD_W-1:0] out_payload;
  logic [PQ_WORD_W-1:0] out_handle;

  logic [PQ_MASK_W-1:0] cur_mask = '0;
  bit                   no_idle = 1'b0;
  bit                   stall_hold_req = 1'b0;
  int                   cycle_count = 0;

  event_queue_scoreboard board = new(PQ_DEPTH_DEF);

  priority_event_queue_top #(
    .QUEUE_DEPTH(PQ_DEPTH_DEF)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_receiver_id (in_receiver_id),
    .in_sender_id   (in_sender_id),
    .in_kind        (in_kind),
    .in_tag         (in_tag),
    .in_payload_word(in_payload_word),
    .in_data_handle (in_data_handle),
    .in_urgency     (in_urgency),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_deliver    (out_deliver),
    .out_receiver   (out_receiver),
    .out_sender     (out_sender),
    .out_kind       (out_kind),
    .out_tag        (out_tag),
    .out_payload    (out_payload),
    .out_handle     (out_handle)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // request side monitor
  always @(posedge clk) begin
    event_rec_t ev;
    if (rst_n && in_valid && !in_stall) begin
      ev.receiver = in_receiver_id;
      ev.sender   = in_sender_id;
      ev.kind     = in_kind;
      ev.tag      = in_tag;
      ev.payload  = in_payload_word;
      ev.handle   = in_data_handle;
      ev.urgency  = in_urgency;
      board.note_request(in_req_type == REQ_POP, ev);
    end
  end

  always @(posedge clk) begin
    if (rst_n && cfg_wr_en) begin
      board.rx_mask = cfg_wr_data;
    end
  end

  // result side monitor
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.status   = status_t'(out_status);
      got.deliver  = out_deliver;
      got.receiver = out_receiver;
      got.sender   = out_sender;
      got.kind     = out_kind;
      got.tag      = out_tag;
      got.payload  = out_payload;
      got.handle   = out_handle;
      board.check_result(got);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (stall_hold_req) begin
        stall_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic send_request(logic req, event_rec_t ev);
    @(negedge clk);
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_receiver_id  <= ev.receiver;
    in_sender_id    <= ev.sender;
    in_kind         <= ev.kind;
    in_tag          <= ev.tag;
    in_payload_word <= ev.payload;
    in_data_handle  <= ev.handle;
    in_urgency      <= ev.urgency;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // wait until every request has its result, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(logic [PQ_MASK_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    cur_mask     = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic event_rec_t random_event();
    event_rec_t ev;
    ev.receiver = PQ_ID_W'($urandom_range(31));
    // mostly enabled receivers so that pushes get into the queue
    if (cur_mask != '0 && $urandom_range(99) < 85)
      while (!cur_mask[ev.receiver]) ev.receiver = PQ_ID_W'($urandom_range(31));
    ev.sender  = PQ_ID_W'($urandom_range(31));
    ev.kind    = PQ_BYTE_W'($urandom_range(255));
    ev.tag     = PQ_BYTE_W'($urandom_range(255));
    ev.payload = $urandom;
    ev.handle  = $urandom;
    // narrow urgency range most of the time so that ties are common
    ev.urgency = PQ_BYTE_W'(($urandom_range(99) < 70) ? $urandom_range(7)
                                                       : $urandom_range(255));
    return ev;
  endfunction

  task automatic run_random(int count, int push_pct);
    event_rec_t ev;
    logic       req;
    repeat (count) begin
      if (!no_idle && $urandom_range(99) < IDLE_PCT) pause_sender($urandom_range(6, 1));
      ev  = random_event();
      req = ($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP;
      send_request(req, ev);
    end
  endtask

  initial begin
    event_rec_t ev;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // mask is clear after reset: push refused, pop of an empty queue
    send_request(REQ_PUSH, event_rec_t'('0));
    send_request(REQ_POP, random_event());
    settle();
    write_mask(32'hFFFF_FFFF);

    // field extremes, then three of equal urgency to check arrival order
    send_request(REQ_PUSH, event_rec_t'{5'd31, 5'd31, 8'hFF, 8'hFF,
                                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF});
    send_request(REQ_PUSH, event_rec_t'{5'd0, 5'd0, 8'h00, 8'h00,
                                        32'h0, 32'h0, 8'h00});
    for (int t = 1; t <= 3; t++) begin
      ev          = random_event();
      ev.receiver = PQ_ID_W'(10 + t);
      ev.tag      = PQ_BYTE_W'(t);
      ev.urgency  = 8'h40;
      send_request(REQ_PUSH, ev);
    end
    settle();

    // receiver 0 disabled while its event is still queued
    write_mask(32'hFFFF_FFFE);
    send_request(REQ_POP, random_event());
    send_request(REQ_POP, random_event());

    // fill every slot, then a push into a full queue and one to a disabled
    // receiver, which is refused for the receiver first
    repeat (13) begin
      ev          = random_event();
      ev.receiver = PQ_ID_W'($urandom_range(31, 1));
      send_request(REQ_PUSH, ev);
    end
    ev          = random_event();
    ev.receiver = 5'd5;
    send_request(REQ_PUSH, ev);
    ev.receiver = 5'd0;
    send_request(REQ_PUSH, ev);
    settle();

    write_mask($urandom);
    run_random(150, 55);
    settle();

    no_idle = 1'b1;
    write_mask(32'h8000_0001);
    run_random(120, 50);
    settle();
    no_idle = 1'b0;

    // long receiver hold-off while pushes keep coming
    write_mask(32'hFFFF_FFFF);
    stall_hold_req = 1'b1;
    run_random(120, 75);
    settle();

    write_mask(32'h0000_0000);
    run_random(40, 60);
    settle();

    write_mask($urandom);
    run_random(150, 45);
    settle();

    write_mask($urandom | 32'h1);
    run_random(150, 55);
    settle();

    write_mask(32'hFFFF_FFFF);
    run_random(120, 40);
    settle();

    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
